// ===== hdl/four_wheel_steer_odometry_unit_defines.svh =====
// assertion macros for the odometry unit checker
`ifndef FOUR_WHEEL_STEER_ODOMETRY_UNIT_DEFINES_SVH
`define FOUR_WHEEL_STEER_ODOMETRY_UNIT_DEFINES_SVH

// same-cycle implication
`define FWSO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FWSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fwso_pkg.sv =====
package fwso_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
	localparam int ANGLE_W = 35;
	localparam int CXY_W = 27;
	localparam int TRIG_W = 17;

	localparam int DIV_NUM_W = 59;
	localparam int DIV_DEN_W = 39;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic signed [ANGLE_W-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 27'sd10188014;

	localparam logic signed [16:0] PI_Q13 = 17'sd25736;
	localparam logic [16:0] TWO_PI_Q13 = 17'd51472;
	localparam logic signed [24:0] DEN_K = 25'sd13176384;
	// floor(2^28 / 3217), with 51472 = 16 * 3217
	localparam logic signed [17:0] MOD_RECIP = 18'sd83442;

	localparam logic [0:0] REG_AXLE_DIST = 1'b0;
	localparam logic [0:0] REG_TICK_PERIOD = 1'b1;

	localparam logic [14:0] AXLE_DIST_RST = 15'd1065;
	localparam logic [15:0] TICK_PERIOD_RST = 16'd3277;

	function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [CORDIC_CNT_W-1:0] i);
		logic signed [ANGLE_W-1:0] r;
		case (i)
			5'd0: r = 35'sd843314857;
			5'd1: r = 35'sd497837829;
			5'd2: r = 35'sd263043837;
			5'd3: r = 35'sd133525159;
			5'd4: r = 35'sd67021687;
			5'd5: r = 35'sd33543516;
			5'd6: r = 35'sd16775851;
			5'd7: r = 35'sd8388437;
			5'd8: r = 35'sd4194283;
			5'd9: r = 35'sd2097149;
			5'd10: r = 35'sd1048576;
			5'd11: r = 35'sd524288;
			5'd12: r = 35'sd262144;
			5'd13: r = 35'sd131072;
			5'd14: r = 35'sd65536;
			5'd15: r = 35'sd32768;
			5'd16: r = 35'sd16384;
			5'd17: r = 35'sd8192;
			5'd18: r = 35'sd4096;
			5'd19: r = 35'sd2048;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/fwso_cordic.sv =====
module fwso_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [fwso_pkg::ANGLE_W-1:0]    angle,
	output logic                                   done,
	output logic signed [fwso_pkg::TRIG_W-1:0]     cos_val,
	output logic signed [fwso_pkg::TRIG_W-1:0]     sin_val
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [fwso_pkg::CORDIC_CNT_W-1:0]     step_q;
	logic signed [fwso_pkg::CXY_W-1:0]     x_q, y_q;
	logic signed [fwso_pkg::ANGLE_W-1:0]   z_q;
	logic                                  neg_q;
	logic signed [fwso_pkg::ANGLE_W-1:0]   z0;
	logic                                  neg0;
	logic signed [fwso_pkg::CXY_W-1:0]     xs, ys, xr, yr;
	logic signed [fwso_pkg::ANGLE_W-1:0]   at;
	logic signed [fwso_pkg::TRIG_W:0]      cr, sr;

	always_comb begin
		z0 = angle;
		neg0 = 1'b0;
		if (angle > fwso_pkg::HALF_PI_Q30) begin
			z0 = angle - fwso_pkg::PI_Q30;
			neg0 = 1'b1;
		end else if (angle < -fwso_pkg::HALF_PI_Q30) begin
			z0 = angle + fwso_pkg::PI_Q30;
			neg0 = 1'b1;
		end
	end

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = fwso_pkg::atan_q30(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == fwso_pkg::CORDIC_CNT_W'(fwso_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= fwso_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= z0;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// round to q1.15
	assign xr = x_q + 27'sd256;
	assign yr = y_q + 27'sd256;
	assign cr = $signed(xr[fwso_pkg::CXY_W-1:9]);
	assign sr = $signed(yr[fwso_pkg::CXY_W-1:9]);
	assign cos_val = neg_q ? fwso_pkg::TRIG_W'(-cr) : fwso_pkg::TRIG_W'(cr);
	assign sin_val = neg_q ? fwso_pkg::TRIG_W'(-sr) : fwso_pkg::TRIG_W'(sr);
	assign done = done_q;

endmodule

// ===== hdl/fwso_div.sv =====
module fwso_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [fwso_pkg::DIV_NUM_W-1:0]       dividend,
	input  logic [fwso_pkg::DIV_DEN_W-1:0]       divisor,
	output logic                                 done,
	output logic [fwso_pkg::DIV_NUM_W-1:0]       quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [fwso_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [fwso_pkg::DIV_NUM_W-1:0]      quo_q;
	logic [fwso_pkg::DIV_DEN_W-1:0]      rem_q;
	logic [fwso_pkg::DIV_DEN_W-1:0]      den_q;
	logic [fwso_pkg::DIV_DEN_W:0]        trial;
	logic [fwso_pkg::DIV_DEN_W:0]        diff;
	logic                                fits;

	assign trial = {rem_q, quo_q[fwso_pkg::DIV_NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == fwso_pkg::DIV_CNT_W'(fwso_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// restoring, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[fwso_pkg::DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[fwso_pkg::DIV_DEN_W-1:0] : trial[fwso_pkg::DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/four_wheel_steer_odometry_unit.sv =====
// four-wheel-steer odometry integrator
// s_* channel: one transaction per control tick carrying four steering angles
// (q2.13 rad) and four drive commands (q4.11). m_* channel: one transaction per
// input with the updated pose: x and y in q16.16 m (saturating) and heading in
// q2.13 rad wrapped to +-pi.
// apb port: axle distance at 0x0 (q3.12 m), tick_period at 0x4 (q0.16 s).
// each item takes six passes of a 20-step cordic (four wheels, steering skew,
// heading), one restoring division for the yaw step and shared-multiplier
// steps (heading wrap by reciprocal multiply included) before m_tvalid.
// s_tready is high only while the sequencer is idle, so a new item is not
// accepted until the sequencer has finished the previous one.
// the result sits in an output register; a new item may be accepted while it
// waits. if the receiver still stalls when the next result is ready, the
// sequencer holds in its final state until the output register frees up.
// reset clears the pose to zero, loads axle distance 1065 and tick_period 3277.
module four_wheel_steer_odometry_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// steer_0, steer_1, steer_2, steer_3, drive_0, drive_1, drive_2, drive_3
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// position_x, position_y, heading
	output logic [79:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_TRIG_GO, ST_TRIG_WAIT, ST_MUL_C, ST_MUL_S, ST_ACC_S, ST_VEL,
		ST_YAW_VS, ST_YAW_VST, ST_YAW_DEN, ST_DIV_GO, ST_DIV_WAIT,
		ST_ROT_XC, ST_ROT_XS, ST_ROT_RX, ST_ROT_RXT, ST_POS_X,
		ST_ROT_YS, ST_ROT_RY, ST_ROT_RYT, ST_POS_Y,
		ST_MOD_Q, ST_MOD_QD, ST_MOD_R, ST_MOD_FIX, ST_DONE
	} state_t;

	state_t               state_q;
	logic [2:0]           idx_q;
	logic                 out_valid_q;
	logic [14:0]          wb_q;
	logic [15:0]          tp_q;
	logic signed [31:0]   pos_x_q, pos_y_q;
	logic signed [15:0]   yaw_q;
	logic [79:0]          out_q;

	logic signed [15:0]   st_q [4];
	logic signed [15:0]   dr_q [4];
	logic signed [34:0]   ax_q, ay_q;
	logic signed [24:0]   vx_q, vy_q;
	logic signed [16:0]   c_q, s_q;
	logic signed [61:0]   prod_q;
	logic signed [58:0]   num_q;
	logic signed [41:0]   pa_q;
	logic signed [42:0]   r_q;
	logic signed [37:0]   dyaw_q;
	logic                 hneg_q;
	logic [29:0]          hmag_q;
	logic [16:0]          wrem_q;

	logic signed [43:0]   mul_a;
	logic signed [17:0]   mul_b;
	logic signed [15:0]   dr_sel, st_sel;
	logic signed [17:0]   sum_r;
	logic signed [34:0]   angle;
	logic                 cor_start, cor_done;
	logic signed [16:0]   cor_cos, cor_sin;
	logic                 div_start, div_done;
	logic [58:0]          div_num, div_quo;
	logic [38:0]          div_den;
	logic [58:0]          num_mag;
	logic signed [38:0]   h;
	logic [38:0]          h_mag;
	logic [14:0]          wb_eff;
	logic signed [17:0]   tp_ext, wb_ext;
	logic signed [34:0]   axr, ayr;
	logic signed [61:0]   rnd_p;
	logic signed [28:0]   pstep;
	logic [16:0]          wrem_fix;
	logic [16:0]          wrap_m;
	logic signed [16:0]   yaw_new;
	logic [37:0]          q_part;
	logic                 wr_en;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// config port
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			fwso_pkg::REG_AXLE_DIST: prdata = {17'b0, wb_q};
			fwso_pkg::REG_TICK_PERIOD: prdata = {16'b0, tp_q};
			default: prdata = '0;
		endcase
	end

	assign wb_eff = (wb_q == 15'd0) ? 15'd1 : wb_q;
	assign tp_ext = $signed({2'b0, tp_q});
	assign wb_ext = $signed({3'b0, wb_eff});

	assign dr_sel = dr_q[idx_q[1:0]];
	assign st_sel = st_q[idx_q[1:0]];
	assign sum_r = 18'(st_q[0]) + 18'(st_q[1]) - 18'(st_q[2]) - 18'(st_q[3]);

	always_comb begin
		if (idx_q == 3'd4)
			angle = {{2{sum_r[17]}}, sum_r, 15'b0};
		else if (idx_q == 3'd5)
			angle = {{2{yaw_q[15]}}, yaw_q, 17'b0};
		else
			angle = {{2{st_sel[15]}}, st_sel, 17'b0};
	end

	assign cor_start = (state_q == ST_TRIG_GO);

	fwso_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (angle),
		.done    (cor_done),
		.cos_val (cor_cos),
		.sin_val (cor_sin)
	);

	// rounded yaw-step division
	assign num_mag = num_q[58] ? 59'(-num_q) : 59'(num_q);
	assign h = 39'(yaw_q) + 39'(dyaw_q) + 39'(fwso_pkg::PI_Q13);
	assign h_mag = h[38] ? 39'(-h) : 39'(h);
	assign div_start = (state_q == ST_DIV_GO);
	assign div_num = num_mag + 59'(prod_q[38:1]);
	assign div_den = prod_q[38:0];

	fwso_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_C: begin
				mul_a = 44'(dr_sel);
				mul_b = 18'(c_q);
			end
			ST_MUL_S: begin
				mul_a = 44'(dr_sel);
				mul_b = 18'(s_q);
			end
			ST_YAW_VS: begin
				mul_a = 44'(vx_q);
				mul_b = 18'(s_q);
			end
			ST_YAW_VST: begin
				mul_a = 44'($signed(prod_q[41:0]));
				mul_b = tp_ext;
			end
			ST_YAW_DEN: begin
				mul_a = 44'(fwso_pkg::DEN_K);
				mul_b = wb_ext;
			end
			ST_ROT_XC: begin
				mul_a = 44'(vx_q);
				mul_b = 18'(c_q);
			end
			ST_ROT_XS: begin
				mul_a = 44'(vy_q);
				mul_b = 18'(s_q);
			end
			ST_ROT_RXT, ST_ROT_RYT: begin
				mul_a = 44'(r_q);
				mul_b = tp_ext;
			end
			ST_POS_X: begin
				mul_a = 44'(vy_q);
				mul_b = 18'(c_q);
			end
			ST_ROT_YS: begin
				mul_a = 44'(vx_q);
				mul_b = 18'(s_q);
			end
			// heading wrap: quotient estimate, low by at most one
			ST_MOD_Q: begin
				mul_a = {18'b0, h_mag[29:4]};
				mul_b = fwso_pkg::MOD_RECIP;
			end
			ST_MOD_QD: begin
				mul_a = {28'b0, prod_q[43:28]};
				mul_b = 18'(fwso_pkg::TWO_PI_Q13);
			end
			default: ;
		endcase
	end

	assign axr = ax_q + 35'sd512;
	assign ayr = ay_q + 35'sd512;
	assign rnd_p = prod_q + (62'sd1 <<< 32);
	assign pstep = $signed(rnd_p[61:33]);
	assign q_part = div_quo[37:0];
	assign wrem_fix = (wrem_q >= fwso_pkg::TWO_PI_Q13) ?
		(wrem_q - fwso_pkg::TWO_PI_Q13) : wrem_q;
	assign wrap_m = (hneg_q && wrem_fix != 17'd0) ?
		(fwso_pkg::TWO_PI_Q13 - wrem_fix) : wrem_fix;
	assign yaw_new = $signed(wrap_m) - fwso_pkg::PI_Q13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			wb_q <= fwso_pkg::AXLE_DIST_RST;
			tp_q <= fwso_pkg::TICK_PERIOD_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
			yaw_q <= '0;
		end else begin
			if (wr_en) begin
				if (paddr[2] == fwso_pkg::REG_AXLE_DIST)
					wb_q <= pwdata[14:0];
				else
					tp_q <= pwdata[15:0];
			end
			if (state_q == ST_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q <= '0;
						state_q <= ST_TRIG_GO;
					end
				end
				ST_TRIG_GO: state_q <= ST_TRIG_WAIT;
				ST_TRIG_WAIT: begin
					if (cor_done) begin
						if (idx_q == 3'd4)
							state_q <= ST_YAW_VS;
						else if (idx_q == 3'd5)
							state_q <= ST_ROT_XC;
						else
							state_q <= ST_MUL_C;
					end
				end
				ST_MUL_C: state_q <= ST_MUL_S;
				ST_MUL_S: state_q <= ST_ACC_S;
				ST_ACC_S: begin
					idx_q <= idx_q + 3'd1;
					state_q <= (idx_q == 3'd3) ? ST_VEL : ST_TRIG_GO;
				end
				ST_VEL: state_q <= ST_TRIG_GO;
				ST_YAW_VS: state_q <= ST_YAW_VST;
				ST_YAW_VST: state_q <= ST_YAW_DEN;
				ST_YAW_DEN: state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						idx_q <= 3'd5;
						state_q <= ST_TRIG_GO;
					end
				end
				ST_ROT_XC: state_q <= ST_ROT_XS;
				ST_ROT_XS: state_q <= ST_ROT_RX;
				ST_ROT_RX: state_q <= ST_ROT_RXT;
				ST_ROT_RXT: state_q <= ST_POS_X;
				ST_POS_X: begin
					pos_x_q <= sat32(34'(pos_x_q) + 34'(pstep));
					state_q <= ST_ROT_YS;
				end
				ST_ROT_YS: state_q <= ST_ROT_RY;
				ST_ROT_RY: state_q <= ST_ROT_RYT;
				ST_ROT_RYT: state_q <= ST_POS_Y;
				ST_POS_Y: begin
					pos_y_q <= sat32(34'(pos_y_q) + 34'(pstep));
					state_q <= ST_MOD_Q;
				end
				ST_MOD_Q: state_q <= ST_MOD_QD;
				ST_MOD_QD: state_q <= ST_MOD_R;
				ST_MOD_R: state_q <= ST_MOD_FIX;
				ST_MOD_FIX: begin
					yaw_q <= yaw_new[15:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && s_tvalid) begin
			for (int i = 0; i < 4; i++) begin
				st_q[i] <= s_tdata[16*i +: 16];
				dr_q[i] <= s_tdata[64 + 16*i +: 16];
			end
			ax_q <= '0;
			ay_q <= '0;
		end
		if (state_q == ST_TRIG_WAIT && cor_done) begin
			c_q <= cor_cos;
			s_q <= cor_sin;
		end
		if (state_q == ST_MUL_S)
			ax_q <= ax_q + 35'($signed(prod_q[31:0]));
		if (state_q == ST_ACC_S)
			ay_q <= ay_q + 35'($signed(prod_q[31:0]));
		if (state_q == ST_VEL) begin
			vx_q <= $signed(axr[34:10]);
			vy_q <= $signed(ayr[34:10]);
		end
		if (state_q == ST_YAW_DEN)
			num_q <= prod_q[58:0];
		if (state_q == ST_DIV_WAIT && div_done)
			dyaw_q <= num_q[58] ? 38'(-$signed(q_part)) : $signed(q_part);
		if (state_q == ST_ROT_XS || state_q == ST_ROT_YS)
			pa_q <= prod_q[41:0];
		if (state_q == ST_ROT_RX)
			r_q <= 43'(pa_q) - 43'($signed(prod_q[41:0]));
		if (state_q == ST_ROT_RY)
			r_q <= 43'(pa_q) + 43'($signed(prod_q[41:0]));
		if (state_q == ST_MOD_Q) begin
			hneg_q <= h[38];
			hmag_q <= h_mag[29:0];
		end
		if (state_q == ST_MOD_R)
			wrem_q <= 17'(hmag_q - prod_q[29:0]);
		if (state_q == ST_DONE && (!out_valid_q || m_tready))
			out_q <= {yaw_q, pos_y_q, pos_x_q};
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

endmodule

// ===== hdl/fwso_checker.sv =====
`include "four_wheel_steer_odometry_unit_defines.svh"

module fwso_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	`FWSO_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`FWSO_ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`FWSO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")
	`FWSO_ASSERT_IMPLY(a_heading_range, clk, arst_n, m_tvalid, ($signed(m_tdata[79:64]) >= -25736) && ($signed(m_tdata[79:64]) <= 25735), "heading out of range")

endmodule

bind four_wheel_steer_odometry_unit fwso_checker u_fwso_checker (.*);
